// ===== src/crc32rb_pkg.sv =====
// Package for the bytewise reflected CRC-32 block.
// Holds the CRC constants and the input item type; no dependencies.
package crc32rb_pkg;

  localparam int unsigned CrcW  = 32;
  localparam int unsigned ByteW = 8;

  localparam logic [CrcW-1:0]  CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0]  CRC_STD_POLY = 32'hEDB8_8320;
  localparam logic [CrcW-1:0]  CRC_ALT_POLY = 32'h04C1_1DB7;
  localparam logic [ByteW-1:0] CRC_BYTE_MASK = 8'hFF;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_byte;
    logic             last_byte;
  } crc32rb_item_t;

endpackage

// ===== src/crc32rb_fold.sv =====
// Combinational byte fold: preload, XOR in one byte and run eight
// reflected shift steps. Depends on crc32rb_pkg.
module crc32rb_fold (
  input  logic [crc32rb_pkg::CrcW-1:0]  rem_i,
  input  logic [crc32rb_pkg::ByteW-1:0] byte_i,
  input  logic                          first_i,
  input  logic [crc32rb_pkg::CrcW-1:0]  poly_i,
  output logic [crc32rb_pkg::CrcW-1:0]  rem_o
);
  import crc32rb_pkg::*;

  logic [CrcW-1:0] step [ByteW+1];

  always_comb begin
    step[0] = (first_i ? CRC_ALL_ONES : rem_i)
              ^ {{(CrcW-ByteW){1'b0}}, byte_i & CRC_BYTE_MASK};
    for (int k = 0; k < ByteW; k++) begin
      step[k+1] = (step[k] >> 1) ^ (step[k][0] ? poly_i : '0);
    end
  end

  assign rem_o = step[ByteW];

endmodule

// ===== src/crc32_reflected_bytewise.sv =====
// Top level of the bytewise reflected CRC-32 block.
// Instantiates crc32rb_fold; depends on crc32rb_pkg.
//
// Usage:
//   in_*  : message bytes. in_tdata[7:0] is the byte, in_tuser flags the
//           first byte of a message (preload all ones), in_tlast the last.
//   out_* : one request per message, out_tdata = complemented remainder.
//   cfg_* : write of the reflected polynomial; always ready. Reset value
//           0xEDB88320 (standard CRC-32).
// Throughput: one byte per cycle, including across messages, while out_* is free.
// Path: a last byte passes the input register, then is folded into the result
//   register that drives out_tdata; a busy output holds it in the input register.
// The fold of eight shift steps sits between the input register and the
//   remainder/result registers and sets the cycle time.
// Reset: pipeline and output empty, remainder all ones, standard polynomial.
// Stall: the result waits in the output register; bytes keep flowing while
//   no further last byte needs the output, after that in_tready drops.
module crc32_reflected_bytewise (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] crc_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import crc32rb_pkg::*;

  logic            s1_valid_r, s1_valid_nxt;
  crc32rb_item_t   s1_item_r;
  logic [CrcW-1:0] poly_r;
  logic [CrcW-1:0] rem_r;
  logic [CrcW-1:0] rem_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [CrcW-1:0] out_data_r;
  logic            out_free;
  logic            s1_adv;
  logic            in_acc;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  crc32rb_fold u_fold (
    .rem_i   (rem_r),
    .byte_i  (s1_item_r.data_byte),
    .first_i (s1_item_r.first_byte),
    .poly_i  (poly_r),
    .rem_o   (rem_nxt)
  );

  always_comb begin
    s1_valid_nxt  = in_acc || (s1_valid_r && !s1_adv);
    out_valid_nxt = (out_valid_r && !out_tready) || (s1_adv && s1_item_r.last_byte);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= CRC_ALL_ONES;
      poly_r      <= CRC_STD_POLY;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        rem_r <= rem_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        poly_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{data_byte: in_tdata, first_byte: in_tuser, last_byte: in_tlast};
    end
    if (s1_adv && s1_item_r.last_byte) begin
      out_data_r <= ~rem_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input stage empty but not ready");

  a_mid_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_item_r.last_byte) |-> s1_adv)
    else $error("non-last byte held in input stage");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !(s1_adv && s1_item_r.last_byte))
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.last_byte) |=> (out_valid_r && out_data_r == ~rem_r))
    else $error("result missing or not matching remainder");

endmodule
